/* design/keyed_sensor_record_table_defines.svh */
// ----------------------------------------------------------------------------
// keyed sensor record table assertion macros
// Shared clocking and assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_SENSOR_RECORD_TABLE_DEFINES_SVH
`define KEYED_SENSOR_RECORD_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define KSRT_CLK_RST @(posedge clock) disable iff (reset)
`define KSRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (`KSRT_CLK_RST prop) else $error(msg);
`else
`define KSRT_CLK_RST
`define KSRT_ASSERT(lbl, prop, msg)
`endif

`endif

/* design/ksrt_pkg.sv */
// ----------------------------------------------------------------------------
// ksrt_pkg
// Request codes, result status codes, field widths and sequencer states.
// ----------------------------------------------------------------------------
package ksrt_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 16;
   localparam int VAL_W    = 16;
   localparam int POWER_W  = 32;
   localparam int STATUS_W = 4;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   // request codes
   localparam logic [OP_W-1:0] INS_REQ = 3'd0;
   localparam logic [OP_W-1:0] REM_REQ = 3'd1;
   localparam logic [OP_W-1:0] CH_REQ  = 3'd2;
   localparam logic [OP_W-1:0] SEN_REQ = 3'd3;
   localparam logic [OP_W-1:0] VAL_REQ = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSTALLED  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTS     = 4'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 4'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED    = 4'd3;
   localparam logic [STATUS_W-1:0] ST_CHANGED    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_ABSENT     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_FOUND      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_LIST_ENTRY = 4'd7;
   localparam logic [STATUS_W-1:0] ST_LIST_EMPTY = 4'd8;
   localparam logic [STATUS_W-1:0] ST_INVALID_ID = 4'd9;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

endpackage

/* design/keyed_sensor_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_sensor_record_table
// Keyed table of sensor records with install, remove, change, query and list.
// ----------------------------------------------------------------------------
// Usage: one request word enters on req_* and, for a valid op, gives one or
// more result words on rsp_*; rsp_tlast marks the final result word of each
// request. A request is taken only while the table sequencer is idle. Every
// request with a valid op, but for those below, walks the whole table through
// one registered memory read port, one slot per cycle unless a list result
// waits for the output register. A request with sensor id zero (other than
// list) or an unknown op skips the walk: invalid-id requests go straight to
// the finish state, unknown ops give no result. List holds each occupied
// slot back until the next occupied slot is found and sends the last one as
// the final result word, or a list-empty word when there is none.
// Results sit in an output register; a new request is accepted while the last
// result still waits. When rsp_tready is low the walk pauses as soon as a
// result has nowhere to go, and nothing is dropped.
// Reset invalidates every slot through per-slot valid flops; no clearing pass
// is needed. Key, power and efficiency stores are not cleared.
// ----------------------------------------------------------------------------
`include "keyed_sensor_record_table_defines.svh"

module keyed_sensor_record_table
   import ksrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // op, sensor_id, current, voltage, efficiency, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // status, entry_id, entry_power, entry_efficiency, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

   // table stores
   logic [ID_W-1:0]    key_mem [TABLE_ENTRIES];
   logic [POWER_W-1:0] pow_mem [TABLE_ENTRIES];
   logic [VAL_W-1:0]   eff_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_vld_ff;

   state_type state_ff, state_in;

   // request capture
   logic [OP_W-1:0]    op_ff;
   logic [ID_W-1:0]    id_ff;
   logic [POWER_W-1:0] power_ff;
   logic [VAL_W-1:0]   eff_ff;

   // walk counter and read stage
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_slot_ff;
   logic               rd_occ_ff;
   logic [ID_W-1:0]    rd_key_ff;
   logic [POWER_W-1:0] rd_pow_ff;
   logic [VAL_W-1:0]   rd_eff_ff;

   // walk results
   logic               found_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [POWER_W-1:0] match_pow_ff;
   logic [VAL_W-1:0]   match_eff_ff;
   logic               free_ok_ff;
   logic [IDX_W-1:0]   free_idx_ff;

   // list entry held back until we know whether it is the last one
   logic               pend_vld_ff;
   logic [ID_W-1:0]    pend_id_ff;
   logic [POWER_W-1:0] pend_pow_ff;
   logic [VAL_W-1:0]   pend_eff_ff;

   // output register
   logic                out_vld_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [POWER_W-1:0]  out_pow_ff;
   logic [VAL_W-1:0]    out_eff_ff;
   logic                out_last_ff;

   logic [OP_W-1:0]  req_op;
   logic [ID_W-1:0]  req_id;
   logic [VAL_W-1:0] req_cur, req_volt, req_eff;

   logic req_fire, out_free, is_list, hit, list_emit, consume, issue, scan_done;
   logic finish_fire, out_load;
   logic [STATUS_W-1:0] res_status;
   logic [ID_W-1:0]     res_id;
   logic [POWER_W-1:0]  res_pow;
   logic [VAL_W-1:0]    res_eff;
   logic                res_last;
   logic                key_we, val_we, vld_clr;
   logic [IDX_W-1:0]    waddr;
   logic [IDX_W-1:0]    raddr;

   assign req_op   = req_tdata[2:0];
   assign req_id   = req_tdata[18:3];
   assign req_cur  = req_tdata[34:19];
   assign req_volt = req_tdata[50:35];
   assign req_eff  = req_tdata[66:51];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign is_list    = (op_ff == VAL_REQ);
   assign hit        = rd_occ_ff && (rd_key_ff == id_ff);
   assign raddr      = rd_idx_ff[IDX_W-1:0];

   // an occupied slot while one is already held pushes the held one out
   assign list_emit = is_list && rd_vld_ff && rd_occ_ff && pend_vld_ff;
   assign consume   = rd_vld_ff && (!list_emit || out_free);
   assign issue     = (state_ff == S_SCAN) && (rd_idx_ff != LAST_CNT)
                      && (!rd_vld_ff || consume);
   assign scan_done = (state_ff == S_SCAN) && (rd_idx_ff == LAST_CNT) && !rd_vld_ff;
   assign finish_fire = (state_ff == S_FINISH) && out_free;
   assign rd_vld_in = issue ? 1'b1 : (consume ? 1'b0 : rd_vld_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_op <= VAL_REQ) begin
               if (req_op != VAL_REQ && req_id == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (finish_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // final result of a request and its table update
   always_comb begin
      res_status = ST_ABSENT;
      res_id     = id_ff;
      res_pow    = '0;
      res_eff    = '0;
      res_last   = 1'b1;
      key_we     = 1'b0;
      val_we     = 1'b0;
      vld_clr    = 1'b0;
      waddr      = match_idx_ff;
      if (is_list) begin
         if (pend_vld_ff) begin
            res_status = ST_LIST_ENTRY;
            res_id     = pend_id_ff;
            res_pow    = pend_pow_ff;
            res_eff    = pend_eff_ff;
         end else begin
            res_status = ST_LIST_EMPTY;
         end
      end else if (id_ff == '0) begin
         res_status = ST_INVALID_ID;
      end else begin
         case (op_ff)
            INS_REQ: begin
               waddr = free_idx_ff;
               if (found_ff) begin
                  res_status = ST_EXISTS;
               end else if (free_ok_ff) begin
                  res_status = ST_INSTALLED;
                  key_we     = 1'b1;
                  val_we     = 1'b1;
               end else begin
                  res_status = ST_FULL;
               end
            end
            REM_REQ: begin
               if (found_ff) begin
                  res_status = ST_REMOVED;
                  vld_clr    = 1'b1;
               end
            end
            CH_REQ: begin
               if (found_ff) begin
                  res_status = ST_CHANGED;
                  val_we     = 1'b1;
               end
            end
            SEN_REQ: begin
               if (found_ff) begin
                  res_status = ST_FOUND;
                  res_pow    = match_pow_ff;
                  res_eff    = match_eff_ff;
               end
            end
            default: res_status = ST_ABSENT;
         endcase
      end
   end

   assign out_load = finish_fire || (list_emit && consume);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_vld_ff   <= 1'b0;
         rd_idx_ff   <= '0;
         found_ff    <= 1'b0;
         free_ok_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         slot_vld_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         if (req_fire) begin
            rd_idx_ff   <= '0;
            found_ff    <= 1'b0;
            free_ok_ff  <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else begin
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
            if (consume) begin
               if (hit) begin
                  found_ff <= 1'b1;
               end
               if (!rd_occ_ff) begin
                  free_ok_ff <= 1'b1;
               end
               if (is_list && rd_occ_ff) begin
                  pend_vld_ff <= 1'b1;
               end
            end
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (finish_fire && key_we) begin
            slot_vld_ff[waddr] <= 1'b1;
         end else if (finish_fire && vld_clr) begin
            slot_vld_ff[waddr] <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_op;
         id_ff    <= req_id;
         power_ff <= POWER_W'(req_cur) * POWER_W'(req_volt);
         eff_ff   <= req_eff;
      end
      if (issue) begin
         rd_slot_ff <= raddr;
         rd_occ_ff  <= slot_vld_ff[raddr];
      end
      if (consume) begin
         // keys are unique, so the first hit is the only one
         if (hit && !found_ff) begin
            match_idx_ff <= rd_slot_ff;
            match_pow_ff <= rd_pow_ff;
            match_eff_ff <= rd_eff_ff;
         end
         if (!rd_occ_ff && !free_ok_ff) begin
            free_idx_ff <= rd_slot_ff;
         end
         if (is_list && rd_occ_ff) begin
            pend_id_ff  <= rd_key_ff;
            pend_pow_ff <= rd_pow_ff;
            pend_eff_ff <= rd_eff_ff;
         end
      end
      if (finish_fire) begin
         out_status_ff <= res_status;
         out_id_ff     <= res_id;
         out_pow_ff    <= res_pow;
         out_eff_ff    <= res_eff;
         out_last_ff   <= res_last;
      end else if (list_emit && consume) begin
         out_status_ff <= ST_LIST_ENTRY;
         out_id_ff     <= pend_id_ff;
         out_pow_ff    <= pend_pow_ff;
         out_eff_ff    <= pend_eff_ff;
         out_last_ff   <= 1'b0;
      end
   end

   // table memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (finish_fire && key_we) begin
         key_mem[waddr] <= id_ff;
      end
      if (finish_fire && val_we) begin
         pow_mem[waddr] <= power_ff;
         eff_mem[waddr] <= eff_ff;
      end
      if (issue) begin
         rd_key_ff <= key_mem[raddr];
         rd_pow_ff <= pow_mem[raddr];
         rd_eff_ff <= eff_mem[raddr];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_eff_ff, out_pow_ff, out_id_ff, out_status_ff};

   `KSRT_ASSERT(a_read_only_in_scan, rd_vld_ff |-> state_ff == S_SCAN,
      "read stage busy outside scan")
   `KSRT_ASSERT(a_pend_only_list, pend_vld_ff |-> op_ff == VAL_REQ,
      "held list word outside list")
   `KSRT_ASSERT(a_walk_bound, rd_idx_ff <= LAST_CNT, "walk counter past table end")
   `KSRT_ASSERT(a_one_slot_change,
      $countones(slot_vld_ff) <= $countones($past(slot_vld_ff)) + 1,
      "more than one slot filled at once")

endmodule
